@@ sv/ctft_pkg.sv @@
// Shared constants, types and the CORDIC angle table of the tilt filter.
package ctft_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_CNT_W = $clog2(CORDIC_STEPS);
    localparam int SQRT_STEPS   = 24;
    localparam int SQRT_CNT_W   = $clog2(SQRT_STEPS);

    // Bias divider: (2 * sum + count) / (2 * count)
    localparam int DIV_NUM_W = 34;
    localparam int DIV_MAG_W = DIV_NUM_W - 1;
    localparam int DIV_DEN_W = 17;
    localparam int DIV_CNT_W = $clog2(DIV_MAG_W + 1);

    // Gyro increment: divide by 655360000 = 2^20 * 625, the 625 part by
    // reciprocal multiply, floor(u * RATE_RECIP / 2^41), exact for u < 2^32
    localparam int RATE_NUM_W = 54;
    localparam logic [RATE_NUM_W-1:0] RATE_HALF  = 54'd327680000;
    localparam logic [31:0]           RATE_RECIP = 32'd3518437209;

    localparam logic [15:0] SAT_POS = 16'sd18000;
    localparam logic [15:0] SAT_NEG = -16'sd18000;

    // Configuration register indexes
    localparam logic [1:0] CFG_GYRO_SCALE  = 2'd0;
    localparam logic [1:0] CFG_PERIOD      = 2'd1;
    localparam logic [1:0] CFG_BLEND       = 2'd2;
    localparam logic [1:0] CFG_CAL_COUNT   = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic cal_acc;
        logic div_start;
        logic tilt_start;
        logic mul1;
        logic mul2;
        logic rate_sh;
        logic rate_mul;
        logic bl_mul;
        logic bl_sum;
        logic axis;
        logic wr_bias;
        logic wr_inc;
        logic wr_acc;
        logic out_load;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic calibrating;
        logic cal_last;
        logic div_done;
        logic tilt_done;
        logic out_free;
    } t_sts;

    // atan(2^-i) in units of 0.01/256 degree
    function automatic logic [21:0] atan_lut(input logic [4:0] idx);
        logic [21:0] v;
        case (idx)
            5'd0:  v = 22'd1152000;
            5'd1:  v = 22'd680065;
            5'd2:  v = 22'd359328;
            5'd3:  v = 22'd182400;
            5'd4:  v = 22'd91554;
            5'd5:  v = 22'd45822;
            5'd6:  v = 22'd22916;
            5'd7:  v = 22'd11459;
            5'd8:  v = 22'd5730;
            5'd9:  v = 22'd2865;
            5'd10: v = 22'd1432;
            5'd11: v = 22'd716;
            5'd12: v = 22'd358;
            5'd13: v = 22'd179;
            5'd14: v = 22'd90;
            5'd15: v = 22'd45;
            5'd16: v = 22'd22;
            5'd17: v = 22'd11;
            5'd18: v = 22'd6;
            5'd19: v = 22'd3;
            5'd20: v = 22'd1;
            5'd21: v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

@@ sv/ctft_in_if.sv @@
// Request channel carrying one raw gyro and accelerometer sample.
interface ctft_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] acc_x;
    logic signed [15:0] acc_y;
    logic signed [15:0] acc_z;

    modport source (output valid, rate_x, rate_y, acc_x, acc_y, acc_z, input ready);
    modport sink   (input valid, rate_x, rate_y, acc_x, acc_y, acc_z, output ready);
endinterface

@@ sv/ctft_out_if.sv @@
// Result channel carrying filtered pitch and roll.
interface ctft_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] roll_angle;

    modport source (output valid, pitch_angle, roll_angle, input ready);
    modport sink   (input valid, pitch_angle, roll_angle, output ready);
endinterface

@@ sv/ctft_div.sv @@
// Iterative floor divider, signed numerator by positive denominator, one bit a cycle.
module ctft_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic signed [ctft_pkg::DIV_NUM_W-1:0] i_num,
    input  logic [ctft_pkg::DIV_DEN_W-1:0] i_den,
    output logic                           o_done,
    output logic signed [ctft_pkg::DIV_NUM_W-1:0] o_quot
);
    import ctft_pkg::*;

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_neg;
    logic [DIV_MAG_W-1:0] r_n;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_DEN_W:0]   w_trial;
    logic                 w_ge;

    // Restoring step: negative numerators use ~n so floor falls out of ~q
    assign w_trial = {r_rem, r_n[DIV_MAG_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = DIV_CNT_W'(DIV_MAG_W);
        end else if (r_busy) begin
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == DIV_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[DIV_NUM_W-1];
            r_n   <= i_num[DIV_NUM_W-1] ? ~i_num[DIV_MAG_W-1:0] : i_num[DIV_MAG_W-1:0];
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? DIV_DEN_W'(w_trial - {1'b0, r_den}) : w_trial[DIV_DEN_W-1:0];
            r_n   <= {r_n[DIV_MAG_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? ~{1'b0, r_n} : {1'b0, r_n};
endmodule

@@ sv/ctft_tilt.sv @@
// Accelerometer tilt unit: squares, digit-serial root, then CORDIC vectoring.
module ctft_tilt (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [16:0] i_opp,
    input  logic signed [15:0] i_a,
    input  logic signed [15:0] i_b,
    output logic               o_done,
    output logic signed [15:0] o_angle
);
    import ctft_pkg::*;

    typedef enum logic [3:0] {
        T_IDLE = 4'b0001,
        T_SQ   = 4'b0010,
        T_SQRT = 4'b0100,
        T_CORD = 4'b1000
    } t_tilt_ph;

    t_tilt_ph r_ph, n_ph;
    logic     r_done, n_done;
    logic [SQRT_CNT_W-1:0]   r_scnt;
    logic [CORDIC_CNT_W-1:0] r_ccnt;

    logic [31:0]        r_aa, r_bb;
    logic signed [16:0] r_opp;
    logic [47:0]        r_v;
    logic [25:0]        r_rem;
    logic [23:0]        r_root;
    logic signed [26:0] r_x, r_y;
    logic signed [23:0] r_z;
    logic               r_zero;
    logic signed [15:0] r_angle;

    logic signed [31:0] w_sq_a, w_sq_b;
    logic [25:0]        w_rin, w_trial, w_rem_n;
    logic [23:0]        w_root_n;
    logic signed [26:0] w_xs, w_ys, w_x_n, w_y_n;
    logic signed [23:0] w_at, w_z_n, w_zr;

    assign w_sq_a = i_a * i_a;
    assign w_sq_b = i_b * i_b;

    // Root: two radicand bits per step
    assign w_rin    = {r_rem[23:0], r_v[47:46]};
    assign w_trial  = {r_root, 2'b01};
    assign w_rem_n  = (w_rin >= w_trial) ? w_rin - w_trial : w_rin;
    assign w_root_n = {r_root[22:0], w_rin >= w_trial};

    // CORDIC vectoring step drives y towards zero
    assign w_xs  = r_x >>> r_ccnt;
    assign w_ys  = r_y >>> r_ccnt;
    assign w_at  = 24'(atan_lut(5'(r_ccnt)));
    assign w_x_n = (r_y > 0) ? r_x + w_ys : r_x - w_ys;
    assign w_y_n = (r_y > 0) ? r_y - w_xs : r_y + w_xs;
    assign w_z_n = (r_y > 0) ? r_z + w_at : r_z - w_at;
    assign w_zr  = (w_z_n + 24'sd128) >>> 8;

    always_comb begin
        n_ph   = r_ph;
        n_done = 1'b0;
        case (r_ph)
            T_IDLE: if (i_start) n_ph = T_SQ;
            T_SQ:   n_ph = T_SQRT;
            T_SQRT: if (r_scnt == SQRT_CNT_W'(SQRT_STEPS - 1)) n_ph = T_CORD;
            T_CORD: begin
                if (r_ccnt == CORDIC_CNT_W'(CORDIC_STEPS - 1)) begin
                    n_ph   = T_IDLE;
                    n_done = 1'b1;
                end
            end
            default: n_ph = T_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= T_IDLE;
            r_done <= 1'b0;
        end else begin
            r_ph   <= n_ph;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_ph)
            T_IDLE: begin
                r_aa  <= 32'(w_sq_a);
                r_bb  <= 32'(w_sq_b);
                r_opp <= i_opp;
            end
            T_SQ: begin
                r_v    <= {r_aa + r_bb, 16'b0};
                r_rem  <= '0;
                r_root <= '0;
                r_scnt <= '0;
            end
            T_SQRT: begin
                r_v    <= {r_v[45:0], 2'b00};
                r_rem  <= w_rem_n;
                r_root <= w_root_n;
                r_scnt <= r_scnt + 1'b1;
                r_x    <= 27'({1'b0, w_root_n});
                r_y    <= 27'(r_opp) <<< 8;
                r_z    <= '0;
                r_zero <= (w_root_n == '0) && (r_opp == '0);
                r_ccnt <= '0;
            end
            T_CORD: begin
                r_x    <= w_x_n;
                r_y    <= w_y_n;
                r_z    <= w_z_n;
                r_ccnt <= r_ccnt + 1'b1;
                if (n_done) r_angle <= r_zero ? 16'sd0 : 16'(w_zr);
            end
            default: r_ccnt <= '0;
        endcase
    end

    assign o_done  = r_done;
    assign o_angle = r_angle;
endmodule

@@ sv/ctft_dp.sv @@
// Datapath: configuration, calibration sums, gyro path, blend and result register.
module ctft_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ctft_pkg::t_cmd     i_cmd,
    output ctft_pkg::t_sts     o_sts,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [19:0]        i_cfg_data,
    input  logic signed [15:0] i_rate_x,
    input  logic signed [15:0] i_rate_y,
    input  logic signed [15:0] i_acc_x,
    input  logic signed [15:0] i_acc_y,
    input  logic signed [15:0] i_acc_z,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic signed [15:0] o_pitch_angle,
    output logic signed [15:0] o_roll_angle
);
    import ctft_pkg::*;

    logic [15:0] r_scale, r_alpha, r_count;
    logic [19:0] r_period;
    logic [15:0] r_seen;
    logic signed [31:0] r_sum_x, r_sum_y;
    logic signed [15:0] r_bias_x, r_bias_y;
    logic signed [15:0] r_gx, r_gy, r_ax, r_ay, r_az;
    logic signed [15:0] r_pacc, r_racc;
    logic signed [24:0] r_inc_x, r_inc_y;
    logic signed [32:0] r_p1;
    logic signed [53:0] r_p2;
    logic               r_rneg;
    logic [31:0]        r_ru;
    logic [63:0]        r_rprod;
    logic signed [42:0] r_mp;
    logic signed [33:0] r_ma;
    logic signed [15:0] r_pitch, r_roll;
    logic               r_out_valid;
    logic signed [15:0] r_out_p, r_out_r;

    logic signed [15:0] w_raw, w_bias, w_prev, w_acc;
    logic signed [31:0] w_sum;
    logic signed [24:0] w_inc;
    logic signed [16:0] w_diff, w_opp;
    logic signed [15:0] w_ta;
    logic signed [DIV_NUM_W-1:0] w_num, w_quot;
    logic [DIV_DEN_W-1:0] w_den;
    logic signed [RATE_NUM_W-1:0] w_rnum;
    logic signed [24:0] w_rinc;
    logic               w_div_done, w_tilt_done;
    logic signed [15:0] w_angle;
    logic signed [25:0] w_psum;
    logic [16:0]        w_beta;
    logic signed [43:0] w_bl;
    logic signed [27:0] w_blr;
    logic signed [15:0] w_sat;

    // Axis selection
    assign w_raw  = i_cmd.axis ? r_gy : r_gx;
    assign w_bias = i_cmd.axis ? r_bias_y : r_bias_x;
    assign w_sum  = i_cmd.axis ? r_sum_y : r_sum_x;
    assign w_inc  = i_cmd.axis ? r_inc_y : r_inc_x;
    assign w_prev = i_cmd.axis ? r_roll : r_pitch;
    assign w_acc  = i_cmd.axis ? r_racc : r_pacc;
    assign w_diff = 17'(w_raw) - 17'(w_bias);
    assign w_opp  = i_cmd.axis ? -17'(r_ax) : 17'(r_ay);
    assign w_ta   = i_cmd.axis ? r_ay : r_ax;

    // Bias divider operands, rounded half up
    assign w_num = (DIV_NUM_W'(w_sum) <<< 1) + $signed(DIV_NUM_W'(r_count));
    assign w_den = {r_count, 1'b0};

    // Gyro increment: floor shift by 2^20, then reciprocal of 625 on the magnitude;
    // negative numerators use ~m so the floor falls out of ~q
    assign w_rnum = r_p2 + $signed(RATE_HALF);
    assign w_rinc = r_rneg ? ~{2'b00, r_rprod[63:41]} : {2'b00, r_rprod[63:41]};

    ctft_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    ctft_tilt u_tilt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.tilt_start),
        .i_opp   (w_opp),
        .i_a     (w_ta),
        .i_b     (r_az),
        .o_done  (w_tilt_done),
        .o_angle (w_angle)
    );

    // Blend arithmetic
    assign w_psum = 26'(w_prev) + 26'(w_inc);
    assign w_beta = 17'h10000 - {1'b0, r_alpha};
    assign w_bl   = 44'(r_mp) + 44'(r_ma) + 44'sd32768;
    assign w_blr  = w_bl[43:16];
    assign w_sat  = (w_blr > 28'sd18000)  ? $signed(SAT_POS) :
                    (w_blr < -28'sd18000) ? $signed(SAT_NEG) : 16'(w_blr);

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale  <= 16'd573;
            r_period <= 20'd20000;
            r_alpha  <= 16'd61604;
            r_count  <= 16'd1000;
            r_seen   <= '0;
            r_sum_x  <= '0;
            r_sum_y  <= '0;
            r_bias_x <= '0;
            r_bias_y <= '0;
            r_pitch  <= '0;
            r_roll   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_GYRO_SCALE: r_scale  <= i_cfg_data[15:0];
                    CFG_PERIOD:     r_period <= i_cfg_data;
                    CFG_BLEND:      r_alpha  <= i_cfg_data[15:0];
                    CFG_CAL_COUNT:  r_count  <= i_cfg_data[15:0];
                    default:        r_scale  <= r_scale;
                endcase
            end
            if (i_cmd.cal_acc) begin
                r_sum_x <= r_sum_x + 32'(r_gx);
                r_sum_y <= r_sum_y + 32'(r_gy);
                r_seen  <= r_seen + 1'b1;
            end
            if (i_cmd.wr_bias) begin
                if (i_cmd.axis) r_bias_y <= 16'(w_quot);
                else            r_bias_x <= 16'(w_quot);
            end
            if (i_cmd.bl_sum) begin
                if (i_cmd.axis) r_roll  <= w_sat;
                else            r_pitch <= w_sat;
            end
            if (i_cmd.out_load)        r_out_valid <= 1'b1;
            else if (i_out_ready)      r_out_valid <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_gx <= i_rate_x;
            r_gy <= i_rate_y;
            r_ax <= i_acc_x;
            r_ay <= i_acc_y;
            r_az <= i_acc_z;
        end
        if (i_cmd.wr_acc) begin
            if (i_cmd.axis) r_racc <= w_angle;
            else            r_pacc <= w_angle;
        end
        if (i_cmd.wr_inc) begin
            if (i_cmd.axis) r_inc_y <= w_rinc;
            else            r_inc_x <= w_rinc;
        end
        if (i_cmd.mul1) r_p1 <= 33'(w_diff * $signed({1'b0, r_scale}));
        if (i_cmd.mul2) r_p2 <= 54'(r_p1 * $signed({1'b0, r_period}));
        if (i_cmd.rate_sh) begin
            r_rneg <= w_rnum[RATE_NUM_W-1];
            r_ru   <= w_rnum[RATE_NUM_W-1] ? ~w_rnum[51:20] : w_rnum[51:20];
        end
        if (i_cmd.rate_mul) r_rprod <= r_ru * RATE_RECIP;
        if (i_cmd.bl_mul) begin
            r_mp <= 43'($signed({1'b0, r_alpha}) * w_psum);
            r_ma <= 34'($signed({1'b0, w_beta}) * w_acc);
        end
        if (i_cmd.out_load) begin
            r_out_p <= r_pitch;
            r_out_r <= r_roll;
        end
    end

    assign o_sts.calibrating = r_seen < r_count;
    assign o_sts.cal_last    = (17'(r_seen) + 17'd1) == 17'(r_count);
    assign o_sts.div_done    = w_div_done;
    assign o_sts.tilt_done   = w_tilt_done;
    assign o_sts.out_free    = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_pitch_angle = r_out_p;
    assign o_roll_angle  = r_out_r;
endmodule

@@ sv/ctft_ctrl.sv @@
// Controller: sequences calibration, tilt, gyro and blend steps for each request.
module ctft_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  ctft_pkg::t_sts i_sts,
    output ctft_pkg::t_cmd o_cmd
);
    import ctft_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE      = 14'b00000000000001,
        S_DECIDE    = 14'b00000000000010,
        S_BIAS_GO   = 14'b00000000000100,
        S_BIAS_WAIT = 14'b00000000001000,
        S_TILT_GO   = 14'b00000000010000,
        S_TILT_WAIT = 14'b00000000100000,
        S_MUL1      = 14'b00000001000000,
        S_MUL2      = 14'b00000010000000,
        S_RATE_SH   = 14'b00000100000000,
        S_RATE_MUL  = 14'b00001000000000,
        S_RATE_WR   = 14'b00010000000000,
        S_BL_MUL    = 14'b00100000000000,
        S_BL_SUM    = 14'b01000000000000,
        S_OUT       = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_axis, n_axis;

    always_comb begin
        n_state = r_state;
        n_axis  = r_axis;
        o_cmd   = '0;
        o_cmd.axis = r_axis;
        case (r_state)
            S_IDLE: begin
                o_cmd.capture = i_in_valid;
                if (i_in_valid) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_axis = 1'b0;
                if (i_sts.calibrating) begin
                    o_cmd.cal_acc = 1'b1;
                    n_state = i_sts.cal_last ? S_BIAS_GO : S_IDLE;
                end else begin
                    n_state = S_TILT_GO;
                end
            end
            S_BIAS_GO: begin
                o_cmd.div_start = 1'b1;
                n_state = S_BIAS_WAIT;
            end
            S_BIAS_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.wr_bias = 1'b1;
                    n_axis  = !r_axis;
                    n_state = r_axis ? S_IDLE : S_BIAS_GO;
                end
            end
            S_TILT_GO: begin
                o_cmd.tilt_start = 1'b1;
                n_state = S_TILT_WAIT;
            end
            S_TILT_WAIT: begin
                if (i_sts.tilt_done) begin
                    o_cmd.wr_acc = 1'b1;
                    n_axis  = !r_axis;
                    n_state = r_axis ? S_MUL1 : S_TILT_GO;
                end
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state = S_RATE_SH;
            end
            S_RATE_SH: begin
                o_cmd.rate_sh = 1'b1;
                n_state = S_RATE_MUL;
            end
            S_RATE_MUL: begin
                o_cmd.rate_mul = 1'b1;
                n_state = S_RATE_WR;
            end
            S_RATE_WR: begin
                o_cmd.wr_inc = 1'b1;
                n_axis  = !r_axis;
                n_state = r_axis ? S_BL_MUL : S_MUL1;
            end
            S_BL_MUL: begin
                o_cmd.bl_mul = 1'b1;
                n_state = S_BL_SUM;
            end
            S_BL_SUM: begin
                o_cmd.bl_sum = 1'b1;
                n_axis  = !r_axis;
                n_state = r_axis ? S_OUT : S_BL_MUL;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_axis  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
        end
    end

    assign o_in_ready = r_state == S_IDLE;
endmodule

@@ sv/imu_complementary_tilt_filter_unit.sv @@
// Top level of the IMU complementary tilt filter.
// Takes one raw gyro x/y and accelerometer x/y/z request at a time and returns filtered
// pitch and roll in 0.01 degree, saturated to +-180 degrees. The first calibration_count
// requests return nothing; the last of them also runs the two bias divisions. After that
// each request runs, per axis, a 24-step square root and CORDIC_STEPS vectoring steps in
// the tilt unit, a gyro increment by two multiplies, a shift and a reciprocal multiply,
// and a blend multiply and sum. A finished result waits in the output register while the
// next request is accepted; a result that is still waiting when the next one is done
// stalls the controller until it is taken.
module imu_complementary_tilt_filter_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [19:0]  i_cfg_data,
    ctft_in_if.sink      i_in,
    ctft_out_if.source   o_out
);
    import ctft_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;

    ctft_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    ctft_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_rate_x      (i_in.rate_x),
        .i_rate_y      (i_in.rate_y),
        .i_acc_x       (i_in.acc_x),
        .i_acc_y       (i_in.acc_y),
        .i_acc_z       (i_in.acc_z),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_pitch_angle (o_out.pitch_angle),
        .o_roll_angle  (o_out.roll_angle)
    );

    assign i_in.ready = w_in_ready;

`ifndef SYNTHESIS
    // Result register is only loaded into a free slot
    a_out_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!o_out.valid || o_out.ready))
        else $error("result loaded over a pending result");

    // One request at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("request accepted while busy");

    // Shared units never finish together
    a_units: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_sts.div_done && w_sts.tilt_done))
        else $error("divider and tilt unit done together");
`endif
endmodule

@@ tb/imu_complementary_tilt_filter_unit_tb.sv @@
// Self-checking testbench of the IMU complementary tilt filter: predicted pitch/roll versus DUT.
module imu_complementary_tilt_filter_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ctft_pkg::*;

    localparam int  SETTLE_CYCLES = 400;
    localparam int  CYCLE_LIMIT   = 3000000;
    localparam int  RANDOM_ITEMS  = 1350;

    // atan(2^-i) in 0.01/256 degree
    localparam longint ANGLE_STEP [24] = '{
        1152000, 680065, 359328, 182400, 91554, 45822, 22916, 11459,
        5730, 2865, 1432, 716, 358, 179, 90, 45, 22, 11, 6, 3, 1, 1, 0, 0};

    typedef struct {
        logic signed [15:0] pitch;
        logic signed [15:0] roll;
    } t_angles;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_idx = CFG_GYRO_SCALE;
    logic [19:0] cfg_data = '0;

    ctft_in_if  in_ch ();
    ctft_out_if out_ch ();

    imu_complementary_tilt_filter_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always #1 i_clk = ~i_clk;

    // Predictor copy of configuration and filter state
    longint       scale_q = 573;
    longint       period_q = 20000;
    longint       alpha_q = 61604;
    longint       cal_count_q = 1000;
    longint       pitch_q = 0;
    longint       roll_q = 0;
    longint       sum_x_q = 0;
    longint       sum_y_q = 0;
    longint       bias_x_q = 0;
    longint       bias_y_q = 0;
    longint       cal_seen_q = 0;

    t_angles      angles_due [$];
    int           mismatches = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           hold_left = 0;
    longint       cycles = 0;

    function automatic longint div_floor(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic longint root_floor(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return longint'(res);
    endfunction

    // atan2(opp, sqrt(a^2 + b^2)) in 0.01 degree via CORDIC vectoring
    function automatic longint accel_tilt(longint opp, longint a, longint b);
        longint x, y, z, xs, ys;
        x = root_floor(longint'(a * a + b * b) << 16);
        y = opp * 256;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                z = z + ANGLE_STEP[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - ANGLE_STEP[i];
            end
        end
        return (z + 128) >>> 8;
    endfunction

    function automatic longint gyro_increment(longint raw, longint bias);
        return div_floor((raw - bias) * scale_q * period_q + 327680000, 655360000);
    endfunction

    function automatic longint blend_angle(longint prev, longint inc, longint acc);
        longint r;
        r = (alpha_q * (prev + inc) + (65536 - alpha_q) * acc + 32768) >>> 16;
        if (r > 18000) r = 18000;
        if (r < -18000) r = -18000;
        return r;
    endfunction

    // Advance the predictor by one accepted request
    task automatic predict_angles(input logic signed [15:0] gx, gy, ax, ay, az);
        t_angles e;
        if (cal_seen_q < cal_count_q) begin
            sum_x_q += gx;
            sum_y_q += gy;
            cal_seen_q++;
            if (cal_seen_q == cal_count_q) begin
                bias_x_q = div_floor(2 * sum_x_q + cal_count_q, 2 * cal_count_q);
                bias_y_q = div_floor(2 * sum_y_q + cal_count_q, 2 * cal_count_q);
            end
        end else begin
            pitch_q = blend_angle(pitch_q, gyro_increment(gx, bias_x_q),
                                  accel_tilt(ay, ax, az));
            roll_q  = blend_angle(roll_q, gyro_increment(gy, bias_y_q),
                                  accel_tilt(-longint'(ax), ay, az));
            e.pitch = pitch_q[15:0];
            e.roll  = roll_q[15:0];
            angles_due.push_back(e);
        end
    endtask

    // Drive one request and wait for its handshake
    task automatic send_sample(input logic signed [15:0] gx, gy, ax, ay, az);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid  = 1'b1;
        in_ch.rate_x = gx;
        in_ch.rate_y = gy;
        in_ch.acc_x  = ax;
        in_ch.acc_y  = ay;
        in_ch.acc_z  = az;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_angles(gx, gy, ax, ay, az);
    endtask

    task automatic send_random(input bit at_rest);
        logic signed [15:0] ax, ay, az;
        ax = 16'($urandom);
        ay = 16'($urandom);
        az = 16'($urandom);
        if (at_rest) begin
            ax = $signed(16'($urandom_range(4000))) - 16'sd2000;
            ay = $signed(16'($urandom_range(4000))) - 16'sd2000;
            az = 16'sd16384 - $signed(16'($urandom_range(1000)));
        end
        send_sample(16'($urandom), 16'($urandom), ax, ay, az);
    endtask

    // Wait until every predicted result has come and the block has settled
    task automatic drain_results();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (angles_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input longint value);
        @(negedge i_clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = value[19:0];
        @(negedge i_clk);
        cfg_we   = 1'b0;
        case (idx)
            CFG_GYRO_SCALE: scale_q     = value & 16'hFFFF;
            CFG_PERIOD:     period_q    = value & 20'hFFFFF;
            CFG_BLEND:      alpha_q     = value & 16'hFFFF;
            CFG_CAL_COUNT:  cal_count_q = value & 16'hFFFF;
            default: ;
        endcase
    endtask

    // Receiver: random stalls, plus a long hold-off when requested
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            out_ch.ready = 1'b0;
            hold_left = hold_left - 1;
        end else begin
            out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each delivered result with the oldest prediction
    always @(posedge i_clk) begin
        t_angles e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (angles_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result pitch=%0d roll=%0d",
                             out_ch.pitch_angle, out_ch.roll_angle);
            end else begin
                e = angles_due.pop_front();
                if (e.pitch !== out_ch.pitch_angle || e.roll !== out_ch.roll_angle) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: pitch exp %0d got %0d, roll exp %0d got %0d",
                                 e.pitch, out_ch.pitch_angle, e.roll, out_ch.roll_angle);
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles = cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("imu_complementary_tilt_filter_unit regression: fail");
            $finish;
        end
    end

    // Calibration runs, count raised, lowered, zero and at maximum
    task automatic test_calibration();
        write_reg(CFG_CAL_COUNT, 3);
        send_sample(16'sd100, -16'sd50, 0, 0, 16'sd16384);
        send_sample(16'sd101, -16'sd51, 0, 0, 16'sd16384);
        send_sample(16'sd103, -16'sd52, 0, 0, 16'sd16384);
        send_sample(16'sd140, -16'sd90, 0, 0, 16'sd16384);
        drain_results();
        write_reg(CFG_CAL_COUNT, 5);
        send_sample(-16'sd32768, 16'sd32767, 16'sd10, 16'sd20, 16'sd16000);
        send_sample(16'sd32767, -16'sd32768, 16'sd10, 16'sd20, 16'sd16000);
        send_sample(16'sd5, 16'sd5, 16'sd10, 16'sd20, 16'sd16000);
        drain_results();
        write_reg(CFG_CAL_COUNT, 65535);
        send_sample(16'sd7, -16'sd7, 0, 0, 0);
        send_sample(16'sd9, -16'sd9, 0, 0, 0);
        drain_results();
        write_reg(CFG_CAL_COUNT, 1);
        send_sample(16'sd9, -16'sd9, 16'sd300, -16'sd300, 16'sd16000);
        drain_results();
        write_reg(CFG_CAL_COUNT, 0);
        send_sample(16'sd9, -16'sd9, 16'sd300, -16'sd300, 16'sd16000);
        drain_results();
    endtask

    // Field extremes, zero vector, saturation and register extremes
    task automatic test_extremes();
        send_sample(0, 0, 0, 0, 0);
        send_sample(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
        send_sample(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
        send_sample(0, 0, 16'sd32767, 0, 0);
        send_sample(0, 0, 0, -16'sd32768, 0);
        send_sample(0, 0, 0, 0, -16'sd32768);
        drain_results();
        write_reg(CFG_GYRO_SCALE, 65535);
        write_reg(CFG_PERIOD, 1000000);
        write_reg(CFG_BLEND, 65535);
        send_sample(16'sd32767, -16'sd32768, 0, 0, 16'sd16384);
        send_sample(16'sd32767, -16'sd32768, 0, 0, 16'sd16384);
        send_sample(-16'sd32768, 16'sd32767, 0, 0, 16'sd16384);
        drain_results();
        write_reg(CFG_PERIOD, 20'hFFFFF);
        write_reg(CFG_BLEND, 0);
        send_sample(16'sd32767, 16'sd32767, 16'sd1000, -16'sd1000, 16'sd100);
        drain_results();
        write_reg(CFG_GYRO_SCALE, 0);
        write_reg(CFG_BLEND, 32768);
        send_sample(16'sd32767, 16'sd32767, 16'sd200, 16'sd200, 16'sd200);
        drain_results();
        write_reg(CFG_GYRO_SCALE, 1);
        write_reg(CFG_PERIOD, 0);
        send_sample(16'sd32767, 16'sd32767, -16'sd200, 16'sd200, -16'sd200);
        drain_results();
        write_reg(CFG_PERIOD, 1);
        send_sample(-16'sd32768, 16'sd32767, -16'sd200, -16'sd200, 16'sd200);
        drain_results();
    endtask

    // Random configurations under the four idling patterns
    task automatic test_random_phases();
        int per_phase;
        per_phase = RANDOM_ITEMS / 12;
        for (int p = 0; p < 12; p++) begin
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            write_reg(CFG_GYRO_SCALE, $urandom_range(65535));
            write_reg(CFG_PERIOD, ($urandom_range(3) == 0) ? $urandom_range(1000000)
                                                          : $urandom_range(1, 40000));
            write_reg(CFG_BLEND, ($urandom_range(3) == 0) ? $urandom_range(65535)
                                                         : $urandom_range(55000, 65535));
            if ($urandom_range(1) == 0)
                write_reg(CFG_CAL_COUNT, cal_seen_q + $urandom_range(4));
            for (int n = 0; n < per_phase; n++)
                send_random($urandom_range(3) != 0);
            drain_results();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    // Output held off long enough for the block to back up its input
    task automatic test_backpressure();
        hold_left = 4000;
        for (int n = 0; n < 12; n++)
            send_random(1'b1);
        drain_results();
        for (int n = 0; n < 6; n++)
            send_random(1'b0);
        drain_results();
    endtask

    initial begin
        in_ch.valid  = 1'b0;
        in_ch.rate_x = '0;
        in_ch.rate_y = '0;
        in_ch.acc_x  = '0;
        in_ch.acc_y  = '0;
        in_ch.acc_z  = '0;
        out_ch.ready = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_calibration();
        test_extremes();
        test_random_phases();
        test_backpressure();

        drain_results();
        if (mismatches == 0 && angles_due.size() == 0)
            $display("imu_complementary_tilt_filter_unit regression: pass");
        else
            $display("imu_complementary_tilt_filter_unit regression: fail");
        $finish;
    end

endmodule

@@ files.f @@
sv/ctft_pkg.sv
sv/ctft_in_if.sv
sv/ctft_out_if.sv
sv/ctft_div.sv
sv/ctft_tilt.sv
sv/ctft_dp.sv
sv/ctft_ctrl.sv
sv/imu_complementary_tilt_filter_unit.sv
tb/imu_complementary_tilt_filter_unit_tb.sv
